// ===== src/sem_pkg.sv =====
// sem_pkg: shared types, codes and constants of the stack expression machine
// no dependencies; imported by every module of the block

package sem_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int SLOT_DEPTH_DEF  = 1024;

    localparam int WORD_W       = 32;
    localparam int SLOT_W       = 16;
    localparam int SLOTS_USED_W = 11;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int DIV_STEPS    = 32;
    localparam int DIV_CNT_W    = 6;

    localparam logic [SLOT_W-1:0] CLAMP_MAX = 16'hFFFF;

    // register index (paddr above the byte lane bits)
    localparam logic [PADDR_W-3:0] REG_SLOTS_USED = '0;

    // operation codes
    localparam logic [3:0] OP_BEGIN  = 4'd0;
    localparam logic [3:0] OP_INIT   = 4'd1;
    localparam logic [3:0] OP_PUSH_C = 4'd2;
    localparam logic [3:0] OP_PUSH_S = 4'd3;
    localparam logic [3:0] OP_ADD    = 4'd4;
    localparam logic [3:0] OP_SUB    = 4'd5;
    localparam logic [3:0] OP_MUL    = 4'd6;
    localparam logic [3:0] OP_DIV    = 4'd7;
    localparam logic [3:0] OP_MAX    = 4'd8;
    localparam logic [3:0] OP_MIN    = 4'd9;
    localparam logic [3:0] OP_STORE  = 4'd10;
    localparam logic [3:0] OP_HALT   = 4'd11;

    typedef enum logic [1:0] {
        RS_OK      = 2'd0,
        RS_HALTED  = 2'd1,
        RS_FAULT   = 2'd2,
        RS_IGNORED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } fsm_state_t;

    typedef struct packed {
        logic [3:0]        operation;
        logic [SLOT_W-1:0] slot_index;
        logic [SLOT_W-1:0] immediate;
    } cmd_t;

    typedef struct packed {
        status_t                  status;
        logic signed [WORD_W-1:0] value;
    } rsp_t;

endpackage

// ===== src/sem_stack_ram.sv =====
// sem_stack_ram: operand stack storage, one write port and two registered read ports
// depends on sem_pkg

module sem_stack_ram
    import sem_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int AW    = $clog2(STACK_DEPTH_DEF)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr_a,
    input  logic [AW-1:0]     raddr_b,
    output logic [WORD_W-1:0] rdata_a,
    output logic [WORD_W-1:0] rdata_b
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== src/sem_slot_ram.sv =====
// sem_slot_ram: slot storage, one write port and one registered read port
// depends on sem_pkg

module sem_slot_ram
    import sem_pkg::*;
#(
    parameter int DEPTH = SLOT_DEPTH_DEF,
    parameter int AW    = $clog2(SLOT_DEPTH_DEF)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [SLOT_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [SLOT_W-1:0] rdata
);

    logic [SLOT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/sem_div.sv =====
// sem_div: signed 32-bit divider, restoring, one quotient bit per cycle
// depends on sem_pkg

module sem_div
    import sem_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    quo_reg, quo_next;
    logic [WORD_W-1:0]    den_reg, den_next;

    logic [WORD_W:0] shifted;
    logic [WORD_W:0] diff;

    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            neg_next  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            rem_next  = '0;
            quo_next  = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
        end
        else if (busy_reg)
        begin
            // trial subtract of the divisor from the shifted remainder
            if (!diff[WORD_W])
            begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ===== src/stack_expression_machine_unit.sv =====
// stack_expression_machine_unit: top level of the stack expression machine
// depends on sem_pkg, sem_stack_ram, sem_slot_ram and sem_div
//
//  channel   direction  handshake          payload
//  cmd       in         cmd_valid/ready    cmd_t: operation, slot_index, immediate
//  rsp       out        rsp_valid/ready    rsp_t: status, value
//  apb       in         psel/penable       slots_used at byte address 0
//
// one item at a time: the accept cycle issues the stack and slot reads, the next
// cycle executes, and writes back once the output register is free
// a divide with a non-zero divisor holds the item in the divider until the
// quotient is handed back
// a result waits in the output register; the next item is accepted meanwhile and
// stalls in execute only until that register frees up
// reset clears the stack pointer, stop flag, slots_used and the output valid flag;
// the stack and slot memories are not cleared

module stack_expression_machine_unit
    import sem_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int SLOT_DEPTH  = SLOT_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // instruction items in
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    // result items out
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp
);

    // stack pointer counts 0..STACK_DEPTH, stack address only indexes entries
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int SLOT_AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam logic [SLOT_W:0] SLOT_LIM  = (SLOT_W + 1)'(SLOT_DEPTH);
    localparam logic [SP_W-1:0] SP_FULL   = SP_W'(STACK_DEPTH);

    // control state
    fsm_state_t             state_reg, state_next;
    logic [SP_W-1:0]        sp_reg;
    logic                   stopped_reg;
    logic [SLOTS_USED_W-1:0] slots_used_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;

    // latched item
    logic [3:0]             op_reg;
    logic [SLOT_W-1:0]      idx_reg;
    logic [SLOT_W-1:0]      imm_reg;

    // handshakes and fsm outputs
    logic cmd_accept;
    logic out_free;
    logic commit;
    logic div_start;
    logic cfg_write;

    // memory read data
    logic [WORD_W-1:0] stk_rd_top;
    logic [WORD_W-1:0] stk_rd_next;
    logic [SLOT_W-1:0] slot_rd;
    logic [SP_W-1:0]   sp_minus1;
    logic [SP_W-1:0]   sp_minus2;

    // divider
    logic              div_done;
    logic [WORD_W-1:0] div_q;

    // execute results
    logic              idx_ok;
    logic              stk_full;
    logic              has_one;
    logic              has_two;
    logic              count_over;
    logic [WORD_W-1:0] alu_value;
    logic [WORD_W-1:0] clamp_value;
    logic              ex_fault;
    status_t           ex_status;
    logic [WORD_W-1:0] ex_value;
    logic              ex_stk_we;
    logic [STK_AW-1:0] ex_stk_waddr;
    logic              ex_slot_we;
    logic [SLOT_W-1:0] ex_slot_wdata;
    logic [SP_W-1:0]   ex_sp;
    logic              ex_stopped;
    logic              ex_div;

    assign cmd_accept = cmd_valid && cmd_ready;
    assign out_free   = !rsp_valid_reg || rsp_ready;

    // ------------------------------------------------------------------
    // configuration port, no wait states; writes land in the access cycle
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[PADDR_W-1:2] == REG_SLOTS_USED);

    always_comb
    begin
        if (paddr[PADDR_W-1:2] == REG_SLOTS_USED)
        begin
            prdata = PDATA_W'(slots_used_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // memories: reads are issued from the current pointer at accept
    // ------------------------------------------------------------------
    assign sp_minus1 = sp_reg - SP_W'(1);
    assign sp_minus2 = sp_reg - SP_W'(2);

    sem_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (STK_AW)
    ) u_stack (
        .clk     (clk),
        .we      (commit && ex_stk_we),
        .waddr   (ex_stk_waddr),
        .wdata   (ex_value),
        .re      (cmd_accept),
        .raddr_a (sp_minus1[STK_AW-1:0]),
        .raddr_b (sp_minus2[STK_AW-1:0]),
        .rdata_a (stk_rd_top),
        .rdata_b (stk_rd_next)
    );

    sem_slot_ram #(
        .DEPTH (SLOT_DEPTH),
        .AW    (SLOT_AW)
    ) u_slots (
        .clk   (clk),
        .we    (commit && ex_slot_we),
        .waddr (idx_reg[SLOT_AW-1:0]),
        .wdata (ex_slot_wdata),
        .re    (cmd_accept),
        .raddr (cmd.slot_index[SLOT_AW-1:0]),
        .rdata (slot_rd)
    );

    sem_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (stk_rd_next),
        .divisor  (stk_rd_top),
        .done     (div_done),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // execute: checks, alu and write-back values from the latched item
    // ------------------------------------------------------------------
    assign idx_ok     = (idx_reg < SLOT_W'(slots_used_reg))
                        && ((SLOT_W + 1)'(idx_reg) < SLOT_LIM);
    assign stk_full   = sp_reg >= SP_FULL;
    assign has_one    = sp_reg != '0;
    assign has_two    = sp_reg >= SP_W'(2);
    assign count_over = (SLOT_W + 1)'(slots_used_reg) > SLOT_LIM;

    // clamp to the unsigned 16-bit range
    always_comb
    begin
        if (stk_rd_top[WORD_W-1])
        begin
            clamp_value = '0;
        end
        else if (|stk_rd_top[WORD_W-2:SLOT_W])
        begin
            clamp_value = WORD_W'(CLAMP_MAX);
        end
        else
        begin
            clamp_value = WORD_W'(stk_rd_top[SLOT_W-1:0]);
        end
    end

    // lhs is the entry below the top, rhs the top
    always_comb
    begin
        unique case (op_reg)
            OP_ADD: alu_value = stk_rd_next + stk_rd_top;
            OP_SUB: alu_value = stk_rd_next - stk_rd_top;
            OP_MUL: alu_value = stk_rd_next * stk_rd_top;
            OP_DIV: alu_value = (stk_rd_top == '0) ? '0 : div_q;
            OP_MAX: alu_value = ($signed(stk_rd_top) < $signed(stk_rd_next))
                                ? stk_rd_next : stk_rd_top;
            OP_MIN: alu_value = ($signed(stk_rd_next) < $signed(stk_rd_top))
                                ? stk_rd_next : stk_rd_top;
            default: alu_value = '0;
        endcase
    end

    always_comb
    begin
        ex_fault      = 1'b0;
        ex_status     = RS_OK;
        ex_value      = '0;
        ex_stk_we     = 1'b0;
        ex_stk_waddr  = sp_reg[STK_AW-1:0];
        ex_slot_we    = 1'b0;
        ex_slot_wdata = imm_reg;
        ex_sp         = sp_reg;
        ex_stopped    = stopped_reg;
        ex_div        = 1'b0;
        if (op_reg == OP_BEGIN)
        begin
            // begin runs even when stopped
            ex_sp      = '0;
            ex_stopped = 1'b0;
            ex_fault   = count_over;
        end
        else if (stopped_reg)
        begin
            ex_status = RS_IGNORED;
        end
        else
        begin
            unique case (op_reg)
                OP_INIT:
                begin
                    if (!idx_ok)
                    begin
                        ex_fault = 1'b1;
                    end
                    else
                    begin
                        ex_slot_we = 1'b1;
                        ex_value   = WORD_W'(imm_reg);
                    end
                end
                OP_PUSH_C, OP_PUSH_S:
                begin
                    if (stk_full || (op_reg == OP_PUSH_S && !idx_ok))
                    begin
                        ex_fault = 1'b1;
                    end
                    else
                    begin
                        ex_value  = (op_reg == OP_PUSH_C) ? WORD_W'(imm_reg)
                                                          : WORD_W'(slot_rd);
                        ex_stk_we = 1'b1;
                        ex_sp     = sp_reg + SP_W'(1);
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN:
                begin
                    if (!has_two)
                    begin
                        ex_fault = 1'b1;
                    end
                    else
                    begin
                        ex_value     = alu_value;
                        ex_stk_we    = 1'b1;
                        ex_stk_waddr = sp_minus2[STK_AW-1:0];
                        ex_sp        = sp_minus1;
                        ex_div       = (op_reg == OP_DIV) && (stk_rd_top != '0);
                    end
                end
                OP_STORE:
                begin
                    if (!idx_ok || !has_one)
                    begin
                        ex_fault = 1'b1;
                    end
                    else
                    begin
                        ex_value      = clamp_value;
                        ex_slot_we    = 1'b1;
                        ex_slot_wdata = clamp_value[SLOT_W-1:0];
                        ex_sp         = sp_minus1;
                    end
                end
                OP_HALT:
                begin
                    ex_stopped = 1'b1;
                    ex_status  = RS_HALTED;
                end
                default:
                begin
                    // unknown opcode
                    ex_fault = 1'b1;
                end
            endcase
        end
        if (ex_fault)
        begin
            ex_stopped = 1'b1;
            ex_status  = RS_FAULT;
            ex_value   = '0;
        end
    end

    // ------------------------------------------------------------------
    // sequencer: accept, execute, optional divide wait
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        commit     = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (ex_div)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done && out_free)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sp_reg         <= '0;
            stopped_reg    <= 1'b0;
            slots_used_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                sp_reg      <= ex_sp;
                stopped_reg <= ex_stopped;
            end
            if (cfg_write)
            begin
                slots_used_reg <= pwdata[SLOTS_USED_W-1:0];
            end
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            op_reg  <= cmd.operation;
            idx_reg <= cmd.slot_index;
            imm_reg <= cmd.immediate;
        end
        if (commit)
        begin
            rsp_reg.status <= ex_status;
            rsp_reg.value  <= $signed(ex_value);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/sem_checker.sv =====
// sem_checker: port-level assertions for the stack expression machine
// depends on sem_pkg; bound to stack_expression_machine_unit below

module sem_checker
    import sem_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    logic [1:0] pending_reg, pending_next;
    logic       cmd_fire;
    logic       rsp_fire;

    assign cmd_fire = cmd_valid && cmd_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // items taken in but not yet handed out
    always_comb
    begin
        pending_next = pending_reg;
        if (cmd_fire && !rsp_fire)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (rsp_fire && !cmd_fire)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> !cmd_ready)
        else $error("item accepted in back-to-back cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire |-> pending_reg != 2'd0)
        else $error("result item without an accepted item");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != RS_OK) |-> rsp.value == '0)
        else $error("non-ok result carries a value");

endmodule

bind stack_expression_machine_unit sem_checker u_sem_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== tb/sem_checker.sv =====
`timescale 1ns / 1ps
// sem_scoreboard: watches the instruction, result and apb channels of the machine,
// predicts each result item and compares it with what the block returns
// depends on sem_pkg only

module sem_scoreboard
    import sem_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    input  logic               cmd_valid,
    input  logic               cmd_ready,
    input  cmd_t               cmd,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  rsp_t               rsp,
    output int                 fail_count,
    output int                 outstanding
);

    logic [WORD_W-1:0]       shadow_stack [STACK_DEPTH_DEF];
    logic [SLOT_W-1:0]       shadow_slots [SLOT_DEPTH_DEF];
    int unsigned             shadow_depth;
    bit                      shadow_stopped;
    logic [SLOTS_USED_W-1:0] shadow_slots_used;
    rsp_t                    result_q [$];
    rsp_t                    oldest;
    int                      errors;

    function automatic bit slot_usable(logic [SLOT_W-1:0] idx);
        return (32'(idx) < 32'(shadow_slots_used)) && (32'(idx) < SLOT_DEPTH_DEF);
    endfunction

    // truncating divide, zero divisor gives zero
    function automatic logic [WORD_W-1:0] quotient(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] ua;
        logic [WORD_W-1:0] ub;
        logic [WORD_W-1:0] q;
        if (b == '0)
            return '0;
        ua = a[WORD_W-1] ? -a : a;
        ub = b[WORD_W-1] ? -b : b;
        q  = ua / ub;
        if (a[WORD_W-1] ^ b[WORD_W-1])
            q = -q;
        return q;
    endfunction

    function automatic logic [WORD_W-1:0] clamp_to_slot(logic [WORD_W-1:0] v);
        if (v[WORD_W-1])
            return '0;
        if (v > 32'(CLAMP_MAX))
            return 32'(CLAMP_MAX);
        return v;
    endfunction

    // one instruction against the shadow machine
    function automatic rsp_t execute_instr(cmd_t c);
        rsp_t              r;
        logic [WORD_W-1:0] lhs;
        logic [WORD_W-1:0] rhs;
        logic [WORD_W-1:0] res;
        bit                fault;
        r.status = RS_OK;
        res      = '0;
        fault    = 1'b0;
        if (c.operation == OP_BEGIN)
        begin
            shadow_depth   = 0;
            shadow_stopped = 1'b0;
            if (32'(shadow_slots_used) > SLOT_DEPTH_DEF)
                fault = 1'b1;
        end
        else if (shadow_stopped)
        begin
            r.status = RS_IGNORED;
        end
        else
        begin
            case (c.operation)
                OP_INIT:
                begin
                    if (!slot_usable(c.slot_index))
                        fault = 1'b1;
                    else
                    begin
                        shadow_slots[c.slot_index] = c.immediate;
                        res = 32'(c.immediate);
                    end
                end
                OP_PUSH_C, OP_PUSH_S:
                begin
                    if (shadow_depth >= STACK_DEPTH_DEF
                        || (c.operation == OP_PUSH_S && !slot_usable(c.slot_index)))
                        fault = 1'b1;
                    else
                    begin
                        res = (c.operation == OP_PUSH_C) ? 32'(c.immediate)
                                                         : 32'(shadow_slots[c.slot_index]);
                        shadow_stack[shadow_depth] = res;
                        shadow_depth++;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN:
                begin
                    if (shadow_depth < 2)
                        fault = 1'b1;
                    else
                    begin
                        rhs = shadow_stack[shadow_depth-1];
                        lhs = shadow_stack[shadow_depth-2];
                        case (c.operation)
                            OP_ADD:  res = lhs + rhs;
                            OP_SUB:  res = lhs - rhs;
                            OP_MUL:  res = lhs * rhs;
                            OP_DIV:  res = quotient(lhs, rhs);
                            OP_MAX:  res = ($signed(rhs) < $signed(lhs)) ? lhs : rhs;
                            default: res = ($signed(lhs) < $signed(rhs)) ? lhs : rhs;
                        endcase
                        shadow_depth--;
                        shadow_stack[shadow_depth-1] = res;
                    end
                end
                OP_STORE:
                begin
                    if (!slot_usable(c.slot_index) || shadow_depth < 1)
                        fault = 1'b1;
                    else
                    begin
                        shadow_depth--;
                        res = clamp_to_slot(shadow_stack[shadow_depth]);
                        shadow_slots[c.slot_index] = res[SLOT_W-1:0];
                    end
                end
                OP_HALT:
                begin
                    shadow_stopped = 1'b1;
                    r.status       = RS_HALTED;
                end
                default:
                    fault = 1'b1;
            endcase
        end
        if (fault)
        begin
            shadow_stopped = 1'b1;
            r.status       = RS_FAULT;
            res            = '0;
        end
        r.value = res;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_depth      = 0;
            shadow_stopped    = 1'b0;
            shadow_slots_used = '0;
            errors            = 0;
            result_q.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result item with nothing expected: status %0d value %0d",
                           rsp.status, rsp.value);
                    errors++;
                end
                else
                begin
                    oldest = result_q.pop_front();
                    if (rsp.status !== oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.status, rsp.status);
                        errors++;
                    end
                    if (rsp.value !== oldest.value)
                    begin
                        $error("value: expected %0d, actual %0d", oldest.value, rsp.value);
                        errors++;
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                result_q.push_back(execute_instr(cmd));
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_SLOTS_USED)
                shadow_slots_used = pwdata[SLOTS_USED_W-1:0];
            fail_count  <= errors;
            outstanding <= result_q.size();
        end
    end

endmodule

// ===== tb/stack_expression_machine_unit_tb.sv =====
`timescale 1ns / 1ps
// stack_expression_machine_unit_tb: drives instruction items and slots_used writes into the
// block, plays the receiver with random stalls and gives the verdict
// depends on sem_pkg, stack_expression_machine_unit and sem_scoreboard

module stack_expression_machine_unit_tb;
    import sem_pkg::*;

    // an opcode outside the instruction set
    localparam logic [3:0] OP_UNKNOWN  = 4'd15;
    // preloaded slots: 0..7 and the top four of the store
    localparam int         PRELOAD_LO  = 8;
    localparam int         PRELOAD_HI  = SLOT_DEPTH_DEF - 4;
    // receiver hold-off used to back the block up
    localparam int         HOLD_CYCLES = 300;
    // cycles with no item moving on either channel before the run is abandoned;
    // the longest honest quiet spell is the hold-off plus a divide
    localparam int         QUIET_LIMIT = 4000;
    // settle time after the last result, covers a full divide
    localparam int         TAIL_CYCLES = 40;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    cmd_t               cmd       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp;

    int fail_count;
    int outstanding;

    // stimulus bookkeeping
    int items_sent     = 0;
    int items_returned = 0;
    int cur_slots_used = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;
    int quiet_cycles   = 0;
    // long hold-offs asked of the receiver so far
    int hold_requests  = 0;
    // slots known to hold a value, so push_slot never reads an unwritten one
    bit slot_filled [SLOT_DEPTH_DEF];

    stack_expression_machine_unit u_top (.*);

    sem_scoreboard u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog: nothing moving for too long means the block has hung
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request, counted here
    initial
    begin : receiver
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                items_returned <= items_returned + 1;
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // a push_slot index that lands inside the program's slots must hit a filled slot;
    // folding onto 0..7 keeps it inside the range since the folded index is never larger
    function automatic logic [SLOT_W-1:0] readable_slot(logic [SLOT_W-1:0] idx);
        if (int'(idx) < cur_slots_used && int'(idx) < SLOT_DEPTH_DEF && !slot_filled[idx])
            return {13'b0, idx[2:0]};
        return idx;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_read_slot();
        if (cur_slots_used >= SLOT_DEPTH_DEF && $urandom_range(0, 3) == 0)
            return 16'(PRELOAD_HI + $urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, PRELOAD_LO - 1));
    endfunction

    function automatic logic [SLOT_W-1:0] pick_write_slot();
        int span;
        span = (cur_slots_used < SLOT_DEPTH_DEF) ? cur_slots_used : SLOT_DEPTH_DEF;
        if (span > 0 && $urandom_range(0, 9) < 8)
            return 16'($urandom_range(0, span - 1));
        return 16'($urandom);
    endfunction

    // constants lean towards the edges of the 16-bit range
    function automatic logic [SLOT_W-1:0] pick_imm();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] pick_binop();
        return 4'(OP_ADD + $urandom_range(0, 5));
    endfunction

    // offers one item and returns at the edge that accepts it; valid stays up so
    // back-to-back items need no second assignment in one step
    task automatic send_item(input logic [3:0] op, input logic [SLOT_W-1:0] idx,
                             input logic [SLOT_W-1:0] imm);
        cmd_t item;
        int   gap;
        item.operation  = op;
        item.slot_index = (op == OP_PUSH_S) ? readable_slot(idx) : idx;
        item.immediate  = imm;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= item;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // sender pause: stop offering and wait for every outstanding result item
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (items_returned != items_sent)
            @(posedge clk);
    endtask

    // apb write of slots_used: setup cycle, then access cycle
    task automatic write_slots_used(input int unsigned n, input logic [PDATA_W-1:0] upper);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({REG_SLOTS_USED, 2'b00});
        pwdata  <= (upper & ~32'h7FF) | 32'(n);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_slots_used = n;
    endtask

    // one program: mostly well-formed with random content, some floods,
    // underflows and stray items in between
    task automatic run_program();
        int kind;
        int len;
        int depth;
        int r;
        kind = $urandom_range(0, 19);
        send_item(OP_BEGIN, 16'($urandom), 16'($urandom));
        if (kind == 0)
        begin
            // pushes one or two past the top of the stack
            repeat (STACK_DEPTH_DEF + $urandom_range(1, 2))
                send_item(OP_PUSH_C, 16'($urandom), pick_imm());
        end
        else if (kind == 1)
        begin
            // underflow, then an item the stopped machine ignores
            send_item(pick_binop(), 16'($urandom), 16'($urandom));
            send_item(OP_PUSH_C, 16'($urandom), pick_imm());
        end
        else
        begin
            depth = 0;
            len   = $urandom_range(2, 16);
            repeat (len)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    send_item(4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom));
                else if (depth < 2 || (r < 45 && depth < STACK_DEPTH_DEF))
                begin
                    if (r[0])
                        send_item(OP_PUSH_S, pick_read_slot(), 16'($urandom));
                    else
                        send_item(OP_PUSH_C, 16'($urandom), pick_imm());
                    depth++;
                end
                else if (r < 78)
                begin
                    send_item(pick_binop(), 16'($urandom), 16'($urandom));
                    depth--;
                end
                else if (r < 90)
                begin
                    send_item(OP_STORE, pick_write_slot(), 16'($urandom));
                    depth--;
                end
                else
                    send_item(OP_INIT, pick_write_slot(), pick_imm());
            end
            if (kind < 12)
                send_item(OP_HALT, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic run_items(input int n);
        int goal;
        goal = items_sent + n;
        while (items_sent < goal)
            run_program();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full slot range, then fill the slots that push_slot may read
        write_slots_used(SLOT_DEPTH_DEF, '0);
        send_item(OP_BEGIN, '0, '0);
        for (int i = 0; i < PRELOAD_LO; i++)
        begin
            send_item(OP_INIT, 16'(i), pick_imm());
            slot_filled[i] = 1'b1;
        end
        for (int i = PRELOAD_HI; i < SLOT_DEPTH_DEF; i++)
        begin
            send_item(OP_INIT, 16'(i), pick_imm());
            slot_filled[i] = 1'b1;
        end

        // directed: build the most negative word, divide it by -1
        send_item(OP_BEGIN, 16'hFFFF, 16'hFFFF);
        send_item(OP_PUSH_C, 16'hFFFF, 16'h8000);
        send_item(OP_PUSH_C, '0, 16'hFFFF);
        send_item(OP_PUSH_C, '0, 16'h0001);
        send_item(OP_ADD, '0, '0);
        send_item(OP_MUL, '0, '0);
        send_item(OP_PUSH_C, '0, '0);
        send_item(OP_PUSH_C, '0, 16'h0001);
        send_item(OP_SUB, '0, '0);
        send_item(OP_DIV, '0, '0);
        // negative value clamps to zero on store
        send_item(OP_STORE, 16'd8, '0);
        // large value clamps to the top of the slot range
        send_item(OP_PUSH_C, '0, 16'hFFFF);
        send_item(OP_PUSH_C, '0, 16'h0002);
        send_item(OP_MUL, '0, '0);
        send_item(OP_STORE, 16'd9, '0);
        // zero divisor, max, then a store to an index beyond the slots
        send_item(OP_PUSH_S, 16'(SLOT_DEPTH_DEF - 1), '0);
        send_item(OP_PUSH_C, '0, '0);
        send_item(OP_DIV, '0, '0);
        send_item(OP_PUSH_S, 16'd3, '0);
        send_item(OP_MAX, '0, '0);
        send_item(OP_STORE, 16'hFFFF, '0);
        // underflow, then an ignored item while stopped
        send_item(OP_BEGIN, '0, '0);
        send_item(OP_ADD, '0, '0);
        send_item(OP_PUSH_C, '0, 16'h1234);
        // opcode outside the set, then halt
        send_item(OP_BEGIN, '0, '0);
        send_item(OP_UNKNOWN, 16'hFFFF, 16'hFFFF);
        send_item(OP_BEGIN, '0, '0);
        send_item(OP_HALT, '0, '0);

        // no idling
        run_items(180);

        // no slots at all, sender mostly idle
        drain();
        write_slots_used(0, '0);
        idle_pct = 79;
        run_items(110);

        // random slot count, receiver mostly stalling; junk in the upper data bits
        drain();
        write_slots_used($urandom_range(1, SLOT_DEPTH_DEF - 1), $urandom);
        idle_pct  = 0;
        stall_pct <= 79;
        run_items(90);
        drain();
        run_items(90);

        // slot count past the store: every begin faults
        drain();
        write_slots_used((1 << SLOTS_USED_W) - 1, '0);
        stall_pct <= 0;
        run_items(30);

        // both sides idle now and then; receiver holds off long enough to back the block up
        drain();
        write_slots_used($urandom_range(1, SLOT_DEPTH_DEF), '0);
        idle_pct  = 12;
        stall_pct <= 12;
        hold_requests++;
        run_items(180);

        // full slot range again, no idling
        drain();
        write_slots_used(SLOT_DEPTH_DEF, '0);
        idle_pct  = 0;
        stall_pct <= 0;
        run_items(95);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sem_pkg.sv
src/sem_stack_ram.sv
src/sem_slot_ram.sv
src/sem_div.sv
src/stack_expression_machine_unit.sv
src/sem_checker.sv
tb/sem_checker.sv
tb/stack_expression_machine_unit_tb.sv
